FILE: rtl/core/vfv_pkg.sv
// Shared types, constants and address functions of the voxel face visibility block.
package vfv_pkg;

  localparam int CHUNK_WIDTH   = 16;
  localparam int CHUNK_HEIGHT  = 64;
  localparam int BLOCK_ID_BITS = 8;

  localparam int ID_W        = BLOCK_ID_BITS;
  localparam int PLANE_SIZE  = CHUNK_WIDTH * CHUNK_HEIGHT;
  localparam int STORE_SIZE  = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_WIDTH;
  localparam int PLANE_DEPTH = 4 * PLANE_SIZE;
  localparam int STORE_AW    = $clog2(STORE_SIZE);
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
  localparam int CLR_LEN     = (STORE_SIZE > PLANE_DEPTH) ? STORE_SIZE : PLANE_DEPTH;
  localparam int CLR_W       = $clog2(CLR_LEN);

  localparam logic [ID_W-1:0] EMPTY_ID = {ID_W{1'b1}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Z          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_PRESENT = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [2:0] REGION_OWN = 3'd0;
  localparam logic [2:0] REGION_ZN  = 3'd1;
  localparam logic [2:0] REGION_XP  = 3'd4;

  localparam logic [1:0] PLANE_ZN = 2'd0;
  localparam logic [1:0] PLANE_ZP = 2'd1;
  localparam logic [1:0] PLANE_XN = 2'd2;
  localparam logic [1:0] PLANE_XP = 2'd3;

  localparam logic [2:0] FACE_PZ = 3'd0;
  localparam logic [2:0] FACE_NZ = 3'd1;
  localparam logic [2:0] FACE_NX = 3'd2;
  localparam logic [2:0] FACE_PX = 3'd3;
  localparam logic [2:0] FACE_PY = 3'd4;
  localparam logic [2:0] FACE_NY = 3'd5;
  localparam logic [2:0] FACE_FIRST = FACE_PZ;
  localparam logic [2:0] FACE_LAST  = FACE_NY;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CENTER,
    ST_FACE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_VOXEL,
    SRC_PLANE,
    SRC_NONE
  } src_t;

  typedef struct packed {
    logic       func;
    logic [2:0] region;
    logic [3:0] cell_x;
    logic [5:0] cell_y;
    logic [3:0] cell_z;
    logic [7:0] block_value;
  } vfv_in_t;

  typedef struct packed {
    logic               solid;
    logic [7:0]         block_id;
    logic [5:0]         face_mask;
    logic signed [15:0] world_x;
    logic [5:0]         world_y;
    logic signed [15:0] world_z;
  } vfv_out_t;

  typedef struct packed {
    src_t                src;
    logic [1:0]          plane;
    logic [STORE_AW-1:0] v_addr;
    logic [PLANE_AW-1:0] p_addr;
  } probe_t;

  function automatic logic [STORE_AW-1:0] cell_index(input logic [3:0] x, input logic [5:0] y,
                                                     input logic [3:0] z);
    return STORE_AW'((int'(z) * CHUNK_WIDTH + int'(x)) * CHUNK_HEIGHT + int'(y));
  endfunction

  function automatic logic [PLANE_AW-1:0] plane_index(input logic [1:0] plane,
                                                      input logic [3:0] h, input logic [5:0] y);
    return PLANE_AW'(int'(plane) * PLANE_SIZE + int'(h) * CHUNK_HEIGHT + int'(y));
  endfunction

  function automatic probe_t face_probe(input logic [2:0] face, input logic [3:0] x,
                                        input logic [5:0] y, input logic [3:0] z);
    probe_t p;
    p.src    = SRC_VOXEL;
    p.plane  = PLANE_ZN;
    p.v_addr = '0;
    p.p_addr = '0;
    case (face)
      FACE_PZ: begin
        if (int'(z) == CHUNK_WIDTH - 1) begin
          p.src    = SRC_PLANE;
          p.plane  = PLANE_ZP;
          p.p_addr = plane_index(PLANE_ZP, x, y);
        end else begin
          p.v_addr = cell_index(x, y, z + 4'd1);
        end
      end
      FACE_NZ: begin
        if (z == 4'd0) begin
          p.src    = SRC_PLANE;
          p.plane  = PLANE_ZN;
          p.p_addr = plane_index(PLANE_ZN, x, y);
        end else begin
          p.v_addr = cell_index(x, y, z - 4'd1);
        end
      end
      FACE_NX: begin
        if (x == 4'd0) begin
          p.src    = SRC_PLANE;
          p.plane  = PLANE_XN;
          p.p_addr = plane_index(PLANE_XN, z, y);
        end else begin
          p.v_addr = cell_index(x - 4'd1, y, z);
        end
      end
      FACE_PX: begin
        if (int'(x) == CHUNK_WIDTH - 1) begin
          p.src    = SRC_PLANE;
          p.plane  = PLANE_XP;
          p.p_addr = plane_index(PLANE_XP, z, y);
        end else begin
          p.v_addr = cell_index(x + 4'd1, y, z);
        end
      end
      FACE_PY: begin
        if (int'(y) == CHUNK_HEIGHT - 1) begin
          p.src = SRC_NONE;
        end else begin
          p.v_addr = cell_index(x, y + 6'd1, z);
        end
      end
      FACE_NY: begin
        if (y == 6'd0) begin
          p.src = SRC_NONE;
        end else begin
          p.v_addr = cell_index(x, y - 6'd1, z);
        end
      end
      default: begin
        p.src = SRC_NONE;
      end
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/vfv_if.sv
// Valid/ready channel interfaces for the input words and the result words.
interface vfv_in_if;
  logic             valid;
  logic             ready;
  vfv_pkg::vfv_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vfv_out_if;
  logic              valid;
  logic              ready;
  vfv_pkg::vfv_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/voxel_face_visibility.sv
// Top level of the voxel face visibility block: cell store, neighbor planes and query sequencer.
//
//   channel  | direction | handshake          | word
//   in_ch    | sink      | valid/ready        | func, region, cell_x/y/z, block_value
//   out_ch   | source    | valid/ready        | solid, block_id, face_mask, world_x/y/z
//   cfg      | sink      | cfg_we, no ready   | cfg_index, cfg_data
//
// A write word is taken while idle and leaves the block idle. A query of a solid cell steps
// through accept, the center read and six neighbor probes, read from the cell store or the neighbor
// planes or none at the top and bottom, then the output load. A query of an empty cell skips the probes.
// After reset a clearing pass fills both memories; no word is accepted then.
// A stalled output holds the finished result, and the next word is taken once it loads.
module voxel_face_visibility (
  input  logic                               clk,
  input  logic                               rst_n,
  vfv_in_if.sink                             in_ch,
  vfv_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [vfv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vfv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [vfv_pkg::ID_W-1:0] voxel_mem [vfv_pkg::STORE_SIZE];
  logic                     plane_mem [vfv_pkg::PLANE_DEPTH];

  vfv_pkg::state_t state_r, state_nxt;
  logic [vfv_pkg::CLR_W-1:0] clr_r;
  logic signed [11:0] chunk_x_r;
  logic signed [11:0] chunk_z_r;
  logic [3:0] present_r;

  logic [3:0] x_r;
  logic [5:0] y_r;
  logic [3:0] z_r;
  logic [vfv_pkg::ID_W-1:0] id_r;
  logic solid_r;
  logic [5:0] mask_r;
  logic [2:0] face_r;
  vfv_pkg::src_t src_r;
  logic [1:0] plane_r;

  logic out_valid_r;
  vfv_pkg::vfv_out_t out_data_r;

  logic [vfv_pkg::ID_W-1:0] v_rd_r;
  logic p_rd_r;

  logic v_en, v_we, p_en, p_we, p_wdata;
  logic [vfv_pkg::STORE_AW-1:0] v_addr;
  logic [vfv_pkg::PLANE_AW-1:0] p_addr;
  logic [vfv_pkg::ID_W-1:0] v_wdata;

  logic accept, in_inside, out_free, center_solid, exposed;
  logic [1:0] wr_plane;
  logic [3:0] wr_h;
  logic [2:0] probe_face;
  vfv_pkg::probe_t probe;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_inside = (int'(in_ch.data.cell_x) < vfv_pkg::CHUNK_WIDTH) &&
                     (int'(in_ch.data.cell_y) < vfv_pkg::CHUNK_HEIGHT) &&
                     (int'(in_ch.data.cell_z) < vfv_pkg::CHUNK_WIDTH);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign center_solid = v_rd_r != vfv_pkg::EMPTY_ID;
  assign wr_plane     = 2'(in_ch.data.region - 3'd1);
  assign wr_h         = (wr_plane == vfv_pkg::PLANE_ZN || wr_plane == vfv_pkg::PLANE_ZP) ?
                        in_ch.data.cell_x : in_ch.data.cell_z;
  assign probe_face   = (state_r == vfv_pkg::ST_CENTER) ? vfv_pkg::FACE_FIRST : face_r + 3'd1;
  assign probe        = vfv_pkg::face_probe(probe_face, x_r, y_r, z_r);

  assign in_ch.ready  = state_r == vfv_pkg::ST_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    case (src_r)
      vfv_pkg::SRC_VOXEL: exposed = v_rd_r == vfv_pkg::EMPTY_ID;
      vfv_pkg::SRC_PLANE: exposed = !present_r[plane_r] || !p_rd_r;
      default:            exposed = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vfv_pkg::ST_CLEAR: begin
        if (clr_r == vfv_pkg::CLR_W'(vfv_pkg::CLR_LEN - 1)) state_nxt = vfv_pkg::ST_IDLE;
      end
      vfv_pkg::ST_IDLE: begin
        if (accept && in_ch.data.func == vfv_pkg::FUNC_QUERY) begin
          state_nxt = in_inside ? vfv_pkg::ST_CENTER : vfv_pkg::ST_OUT;
        end
      end
      vfv_pkg::ST_CENTER: begin
        state_nxt = center_solid ? vfv_pkg::ST_FACE : vfv_pkg::ST_OUT;
      end
      vfv_pkg::ST_FACE: begin
        if (face_r == vfv_pkg::FACE_LAST) state_nxt = vfv_pkg::ST_OUT;
      end
      vfv_pkg::ST_OUT: begin
        if (out_free) state_nxt = vfv_pkg::ST_IDLE;
      end
      default: state_nxt = vfv_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    v_en    = 1'b0;
    v_we    = 1'b0;
    v_addr  = probe.v_addr;
    v_wdata = vfv_pkg::EMPTY_ID;
    p_en    = 1'b0;
    p_we    = 1'b0;
    p_addr  = probe.p_addr;
    p_wdata = 1'b0;
    case (state_r)
      vfv_pkg::ST_CLEAR: begin
        v_en   = int'(clr_r) < vfv_pkg::STORE_SIZE;
        v_we   = 1'b1;
        v_addr = vfv_pkg::STORE_AW'(clr_r);
        p_en   = int'(clr_r) < vfv_pkg::PLANE_DEPTH;
        p_we   = 1'b1;
        p_addr = vfv_pkg::PLANE_AW'(clr_r);
      end
      vfv_pkg::ST_IDLE: begin
        v_addr = vfv_pkg::cell_index(in_ch.data.cell_x, in_ch.data.cell_y, in_ch.data.cell_z);
        p_addr = vfv_pkg::plane_index(wr_plane, wr_h, in_ch.data.cell_y);
        v_wdata = vfv_pkg::ID_W'(in_ch.data.block_value);
        p_wdata = vfv_pkg::ID_W'(in_ch.data.block_value) != vfv_pkg::EMPTY_ID;
        if (accept && in_inside) begin
          if (in_ch.data.func == vfv_pkg::FUNC_QUERY) begin
            v_en = 1'b1;
          end else if (in_ch.data.region == vfv_pkg::REGION_OWN) begin
            v_en = 1'b1;
            v_we = 1'b1;
          end else if (in_ch.data.region >= vfv_pkg::REGION_ZN &&
                       in_ch.data.region <= vfv_pkg::REGION_XP) begin
            p_en = 1'b1;
            p_we = 1'b1;
          end
        end
      end
      vfv_pkg::ST_CENTER: begin
        v_en = center_solid && probe.src == vfv_pkg::SRC_VOXEL;
        p_en = center_solid && probe.src == vfv_pkg::SRC_PLANE;
      end
      vfv_pkg::ST_FACE: begin
        v_en = face_r != vfv_pkg::FACE_LAST && probe.src == vfv_pkg::SRC_VOXEL;
        p_en = face_r != vfv_pkg::FACE_LAST && probe.src == vfv_pkg::SRC_PLANE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_en) begin
      if (v_we) voxel_mem[v_addr] <= v_wdata;
      else v_rd_r <= voxel_mem[v_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      if (p_we) plane_mem[p_addr] <= p_wdata;
      else p_rd_r <= plane_mem[p_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfv_pkg::ST_CLEAR;
      clr_r       <= '0;
      chunk_x_r   <= '0;
      chunk_z_r   <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
      face_r      <= vfv_pkg::FACE_FIRST;
    end else begin
      state_r <= state_nxt;
      if (state_r == vfv_pkg::ST_CLEAR) clr_r <= clr_r + vfv_pkg::CLR_W'(1);
      if (cfg_we) begin
        case (cfg_index)
          vfv_pkg::REG_CHUNK_X:          chunk_x_r <= cfg_data;
          vfv_pkg::REG_CHUNK_Z:          chunk_z_r <= cfg_data;
          vfv_pkg::REG_NEIGHBOR_PRESENT: present_r <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      if (state_r == vfv_pkg::ST_CENTER) begin
        face_r <= vfv_pkg::FACE_FIRST;
      end else if (state_r == vfv_pkg::ST_FACE && face_r != vfv_pkg::FACE_LAST) begin
        face_r <= face_r + 3'd1;
      end
      if (state_r == vfv_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      vfv_pkg::ST_IDLE: begin
        if (accept) begin
          x_r     <= in_ch.data.cell_x;
          y_r     <= in_ch.data.cell_y;
          z_r     <= in_ch.data.cell_z;
          id_r    <= vfv_pkg::EMPTY_ID;
          solid_r <= 1'b0;
          mask_r  <= '0;
        end
      end
      vfv_pkg::ST_CENTER: begin
        id_r    <= v_rd_r;
        solid_r <= center_solid;
        mask_r  <= '0;
        src_r   <= probe.src;
        plane_r <= probe.plane;
      end
      vfv_pkg::ST_FACE: begin
        mask_r[face_r] <= exposed;
        src_r   <= probe.src;
        plane_r <= probe.plane;
      end
      vfv_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_r.solid     <= solid_r;
          out_data_r.block_id  <= 8'(id_r);
          out_data_r.face_mask <= solid_r ? mask_r : 6'd0;
          out_data_r.world_x   <= solid_r ?
              16'(int'(chunk_x_r) * vfv_pkg::CHUNK_WIDTH + int'(x_r)) : 16'sd0;
          out_data_r.world_y   <= solid_r ? y_r : 6'd0;
          out_data_r.world_z   <= solid_r ?
              16'(int'(chunk_z_r) * vfv_pkg::CHUNK_WIDTH + int'(z_r)) : 16'sd0;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == vfv_pkg::ST_CENTER || state_r == vfv_pkg::ST_FACE) |-> !v_we && !p_we)
    else $error("memory write during a query");

  a_query_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
      (accept && in_ch.data.func == vfv_pkg::FUNC_QUERY) |=> !in_ch.ready)
    else $error("input taken while a query is in progress");

  a_empty_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_data_r.solid) |->
        (out_data_r.face_mask == 6'd0 && out_data_r.block_id == 8'(vfv_pkg::EMPTY_ID)))
    else $error("empty result carries face data");

  a_face_in_range: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == vfv_pkg::ST_FACE) |-> face_r <= vfv_pkg::FACE_LAST)
    else $error("face step out of range");
`endif

endmodule
